@@ sv/sat_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sat_pkg
// Types and constants shared by the station activity table modules.
// ---------------------------------------------------------------------------
package sat_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_IDX_W   = 6;

   localparam int FLAG_W        = 3;
   localparam int FLAG_SWITCHED = 0;
   localparam int FLAG_AP       = 1;
   localparam int FLAG_PROBING  = 2;

   typedef enum logic [1:0] {
      ST_IGNORED = 2'd0,
      ST_UPDATED = 2'd1,
      ST_CREATED = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic               source_valid;
      logic [47:0]        station_address;
      logic               power_valid;
      logic signed [7:0]  signal_power;
      logic               freq_valid;
      logic [15:0]        channel_frequency;
      logic               beacon_frame;
      logic               probe_frame;
      logic [31:0]        timestamp;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [31:0]            packet_count;
      logic signed [7:0]      power_avg;
      logic                   chan_switched;
      logic                   is_access_point;
      logic                   probe_seen;
   } rsp_type;

   typedef struct packed {
      logic [47:0]       address;
      logic [31:0]       packets;
      logic [31:0]       seen_time;
      logic signed [7:0] average;
      logic [15:0]       frequency;
      logic [FLAG_W-1:0] flags;
   } slot_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } sat_cmd_type;

   typedef struct packed {
      logic src_valid;
      logic hit;
      logic miss_done;
      logic out_free;
   } sat_sts_type;

endpackage
`default_nettype wire

@@ sv/station_activity_table_unit.sv @@
`default_nettype none
// A transaction is accepted while the sequencer is idle; the scan then reads one table entry
// per cycle from the slot RAM until a hit or the end of the filled entries, and the finish
// step writes the result register. A new transaction is accepted only after the last finishes.
// A waiting result holds the finish step, and with it the next transaction.
// Reset clears the sequencer, the fill count and the result valid; the slot RAM is not cleared.
// ---------------------------------------------------------------------------
// station_activity_table_unit
// Table of wireless stations keyed by source address, with per-station
// packet count, power average, channel and frame-type flags.
// ---------------------------------------------------------------------------
module station_activity_table_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sat_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sat_pkg::rsp_type      rsp_data
);
   import sat_pkg::*;

   sat_cmd_type cmd;
   sat_sts_type sts;

   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sat_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ sv/sat_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sat_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/sat_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sat_ctrl
// Sequencer: accept a transaction, scan the table, then finish the update.
// ---------------------------------------------------------------------------
module sat_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sat_pkg::sat_sts_type sts,
   output sat_pkg::sat_cmd_type      cmd
);
   import sat_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CS_SCAN;
            end
         end
         CS_SCAN: begin
            cmd.scan = 1'b1;
            if (!sts.src_valid || sts.hit || sts.miss_done) begin
               state_in = CS_FINISH;
            end
         end
         CS_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != CS_IDLE);

endmodule
`default_nettype wire

@@ sv/sat_dpath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sat_dpath
// Table memory, scan pointer, entry update and result register.
// ---------------------------------------------------------------------------
module sat_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sat_pkg::req_type     req_data,
   input  wire sat_pkg::sat_cmd_type cmd,
   output sat_pkg::sat_sts_type      sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sat_pkg::rsp_type          rsp_data
);
   import sat_pkg::*;

   req_type           item_ff, item_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              rd_en;
   slot_type          rd_slot;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_type          wr_slot;

   logic              hit;
   logic              table_full;
   status_type        kind;
   logic signed [7:0] power;
   logic [15:0]       freq;
   logic [FLAG_W-1:0] mark;
   logic [8:0]        avg_sum;
   logic [8:0]        avg_adj;

   sat_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_slot)
   );

   // slots fill in index order, so the fill count marks the valid ones
   assign table_full = (fill_ff >= FILL_W'(TABLE_ENTRIES));
   assign hit        = cmp_valid_ff && (rd_slot.address == item_ff.station_address);
   assign rd_en      = cmd.scan && !hit && (scan_ff < fill_ff);

   assign sts.src_valid = item_ff.source_valid;
   assign sts.hit       = hit;
   assign sts.miss_done = (scan_ff >= fill_ff) && !hit;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      power = item_ff.power_valid ? item_ff.signal_power : 8'sd0;
      freq  = item_ff.freq_valid ? item_ff.channel_frequency : 16'd0;
      mark  = '0;
      if (item_ff.beacon_frame) begin
         mark[FLAG_AP] = 1'b1;
      end else if (item_ff.probe_frame) begin
         mark[FLAG_PROBING] = 1'b1;
      end

      if (!item_ff.source_valid) begin
         kind = ST_IGNORED;
      end else if (hit_ff) begin
         kind = ST_UPDATED;
      end else if (table_full) begin
         kind = ST_FULL;
      end else begin
         kind = ST_CREATED;
      end

      // halve toward zero: add one to negative sums before the shift
      avg_sum = {rd_slot.average[7], rd_slot.average} + {power[7], power};
      avg_adj = avg_sum + {8'd0, avg_sum[8]};

      wr_slot           = rd_slot;
      wr_slot.seen_time = item_ff.timestamp;
      wr_slot.frequency = freq;
      if (kind == ST_UPDATED) begin
         wr_addr = cmp_idx_ff;
         if (rd_slot.packets != '1) begin
            wr_slot.packets = rd_slot.packets + 32'd1;
         end
         wr_slot.average = avg_adj[8:1];
         wr_slot.flags   = rd_slot.flags | mark;
         if (rd_slot.frequency != freq) begin
            wr_slot.flags[FLAG_SWITCHED] = 1'b1;
         end
      end else begin
         wr_addr         = fill_ff[IDX_W-1:0];
         wr_slot.address = item_ff.station_address;
         wr_slot.packets = 32'd1;
         wr_slot.average = power;
         wr_slot.flags   = mark;
      end
      wr_en = cmd.finish && ((kind == ST_UPDATED) || (kind == ST_CREATED));

      rsp_data_in        = '0;
      rsp_data_in.status = kind;
      if (wr_en) begin
         rsp_data_in.entry_index     = ENTRY_IDX_W'(wr_addr);
         rsp_data_in.packet_count    = wr_slot.packets;
         rsp_data_in.power_avg       = wr_slot.average;
         rsp_data_in.chan_switched   = wr_slot.flags[FLAG_SWITCHED];
         rsp_data_in.is_access_point = wr_slot.flags[FLAG_AP];
         rsp_data_in.probe_seen      = wr_slot.flags[FLAG_PROBING];
      end
   end

   always_comb begin
      item_in      = item_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      hit_in       = hit_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         item_in      = req_data;
         scan_in      = '0;
         cmp_valid_in = 1'b0;
         hit_in       = 1'b0;
      end
      if (cmd.scan) begin
         cmp_valid_in = rd_en;
         if (rd_en) begin
            scan_in    = scan_ff + FILL_W'(1);
            cmp_idx_in = scan_ff[IDX_W-1:0];
         end
         if (hit) begin
            hit_in = 1'b1;
         end
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (kind == ST_CREATED) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         hit_ff       <= hit_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cmp_idx_ff <= cmp_idx_in;
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ tb/sv/tb_station_activity_table_unit.sv @@
// ---------------------------------------------------------------------------
// tb_station_activity_table_unit
// Self-checking bench for the station activity table. It starts with directed
// frames covering field extremes and flag and average corner cases, then sends
// random frames drawn from an address pool large enough to overflow the table.
// A local copy of the station table predicts every response.
// ---------------------------------------------------------------------------
module tb_station_activity_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sat_pkg::*;

   localparam int   POOL_SIZE    = 80;
   localparam int   TOTAL_FRAMES = 1950;
   localparam int   SECOND_DRAIN = 1000;
   localparam int   CALM_FROM    = 400;
   localparam int   CALM_TO      = 800;
   localparam logic ON           = 1'b1;
   localparam logic OFF          = 1'b0;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   station_activity_table_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // predicted station table
   logic [47:0] station_addr [TABLE_ENTRIES];
   logic [31:0] station_pkts [TABLE_ENTRIES];
   int          station_avg [TABLE_ENTRIES];
   logic [15:0] station_freq [TABLE_ENTRIES];
   logic        station_switched [TABLE_ENTRIES];
   logic        station_ap [TABLE_ENTRIES];
   logic        station_probing [TABLE_ENTRIES];
   int          stations_held = 0;

   logic [47:0] addr_pool [POOL_SIZE];
   req_type     frame_queue [$];
   rsp_type     expected_rsp [$];
   int          accepted_count = 0;
   int          total_frames = 0;
   int          first_drain = -1;
   int          mismatches = 0;
   bit          req_taken = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic rsp_type track_frame(req_type f);
      rsp_type     r;
      int          power;
      int          slot;
      logic [15:0] freq;
      bit          hit;
      r = '0;
      hit = 1'b0;
      slot = 0;
      if (!f.source_valid) begin
         r.status = ST_IGNORED;
         return r;
      end
      power = f.power_valid ? int'($signed(f.signal_power)) : 0;
      freq = f.freq_valid ? f.channel_frequency : 16'd0;
      for (int i = 0; i < stations_held; i++) begin
         if (!hit && station_addr[i] == f.station_address) begin
            hit = 1'b1;
            slot = i;
         end
      end
      if (hit) begin
         if (station_pkts[slot] != 32'hFFFF_FFFF)
            station_pkts[slot]++;
         // int division truncates toward zero
         station_avg[slot] = (station_avg[slot] + power) / 2;
         if (station_freq[slot] != freq)
            station_switched[slot] = 1'b1;
         if (f.beacon_frame)
            station_ap[slot] = 1'b1;
         else if (f.probe_frame)
            station_probing[slot] = 1'b1;
         r.status = ST_UPDATED;
      end else begin
         if (stations_held >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
            return r;
         end
         slot = stations_held;
         stations_held++;
         station_addr[slot] = f.station_address;
         station_pkts[slot] = 32'd1;
         station_avg[slot] = power;
         station_switched[slot] = 1'b0;
         station_ap[slot] = f.beacon_frame;
         station_probing[slot] = !f.beacon_frame && f.probe_frame;
         r.status = ST_CREATED;
      end
      station_freq[slot] = freq;
      r.entry_index = slot[ENTRY_IDX_W-1:0];
      r.packet_count = station_pkts[slot];
      r.power_avg = station_avg[slot][7:0];
      r.chan_switched = station_switched[slot];
      r.is_access_point = station_ap[slot];
      r.probe_seen = station_probing[slot];
      return r;
   endfunction

   function automatic req_type frame(logic sv, logic [47:0] addr, logic pv, logic [7:0] pw,
                                     logic cv, logic [15:0] fq, logic bcn, logic prb,
                                     logic [31:0] ts);
      req_type f;
      f.source_valid = sv;
      f.station_address = addr;
      f.power_valid = pv;
      f.signal_power = pw;
      f.freq_valid = cv;
      f.channel_frequency = fq;
      f.beacon_frame = bcn;
      f.probe_frame = prb;
      f.timestamp = ts;
      return f;
   endfunction

   function automatic req_type random_frame();
      req_type     f;
      int          pick;
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      // a few frames without a source address, a few from unknown stations
      f.source_valid = (pick >= 8);
      if (pick < 10)
         f.station_address = wide[47:0];
      else if (pick < 50)
         f.station_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         f.station_address = addr_pool[$urandom_range(0, 9)];
      f.power_valid = ($urandom_range(0, 99) < 85);
      f.signal_power = 8'($urandom);
      f.freq_valid = ($urandom_range(0, 99) < 90);
      // mostly a home channel per station so the switched flag stays clear a while
      if ($urandom_range(0, 99) < 70)
         f.channel_frequency = 16'd2412 + 16'(f.station_address[2:0]) * 16'd5;
      else
         f.channel_frequency = 16'($urandom);
      f.beacon_frame = ($urandom_range(0, 99) < 20);
      f.probe_frame = ($urandom_range(0, 99) < 35);
      f.timestamp = $urandom;
      return f;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response with no transaction pending: %0h", $realtime, got);
      end else begin
         want = expected_rsp.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
         compare_field("packet_count", 64'(want.packet_count), 64'(got.packet_count));
         compare_field("power_avg", 64'(want.power_avg), 64'(got.power_avg));
         compare_field("chan_switched", 64'(want.chan_switched), 64'(got.chan_switched));
         compare_field("is_access_point", 64'(want.is_access_point),
                       64'(got.is_access_point));
         compare_field("probe_seen", 64'(want.probe_seen), 64'(got.probe_seen));
      end
   endtask

   // monitor: accepted requests feed the table copy, accepted responses are checked
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(track_frame(req_data));
            req_taken = 1'b1;
            accepted_count++;
         end
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (frame_queue.size() != 0
             && !(($urandom_range(0, 99) < 10)
                  && !(accepted_count >= CALM_FROM && accepted_count < CALM_TO))
             && !((accepted_count == first_drain || accepted_count == SECOND_DRAIN)
                  && expected_rsp.size() != 0)) begin
            req_valid <= 1'b1;
            req_data <= frame_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < 10)
                      && !(accepted_count >= CALM_FROM && accepted_count < CALM_TO);
   end

   initial begin
      logic [63:0] wide;
      addr_pool[0] = 48'h0;
      addr_pool[1] = 48'hFFFF_FFFF_FFFF;
      addr_pool[2] = 48'h0000_0000_0001;
      addr_pool[3] = 48'h8000_0000_0000;
      addr_pool[4] = 48'hAAAA_AAAA_AAAA;
      addr_pool[5] = 48'h5555_5555_5555;
      for (int i = 6; i < POOL_SIZE; i++) begin
         wide = {$urandom, $urandom};
         addr_pool[i] = wide[47:0];
      end

      // no source address, with and without the other fields set
      frame_queue.push_back(frame(OFF, addr_pool[1], ON, 8'h7F, ON, 16'hFFFF, ON, ON,
                                  32'hFFFF_FFFF));
      frame_queue.push_back(frame(OFF, addr_pool[0], OFF, 8'h00, OFF, 16'h0000, OFF, OFF,
                                  32'h0));
      // create at the most negative power, then averages that round toward zero
      frame_queue.push_back(frame(ON, addr_pool[0], ON, 8'h80, ON, 16'hFFFF, ON, OFF,
                                  32'h0));
      frame_queue.push_back(frame(ON, addr_pool[0], ON, 8'h7F, ON, 16'hFFFF, OFF, OFF,
                                  32'h1));
      frame_queue.push_back(frame(ON, addr_pool[0], OFF, 8'hFF, ON, 16'h0000, OFF, ON,
                                  32'h2));
      // invalid power and channel count as zero
      frame_queue.push_back(frame(ON, addr_pool[1], OFF, 8'h55, OFF, 16'h1234, OFF, ON,
                                  32'hFFFF_FFFF));
      frame_queue.push_back(frame(ON, addr_pool[1], ON, 8'hFD, OFF, 16'hBEEF, ON, ON,
                                  32'h10));
      frame_queue.push_back(frame(ON, addr_pool[1], ON, 8'hFF, ON, 16'h0000, OFF, OFF,
                                  32'h11));
      frame_queue.push_back(frame(ON, addr_pool[1], ON, 8'h01, ON, 16'h0000, OFF, OFF,
                                  32'h12));
      frame_queue.push_back(frame(ON, addr_pool[1], ON, 8'h00, ON, 16'h0005, OFF, OFF,
                                  32'h13));
      frame_queue.push_back(frame(ON, addr_pool[2], ON, 8'h7F, ON, 16'h096C, OFF, OFF,
                                  32'h8000_0000));
      frame_queue.push_back(frame(ON, addr_pool[2], ON, 8'h7F, ON, 16'h096C, OFF, OFF,
                                  32'h8000_0001));
      frame_queue.push_back(frame(ON, addr_pool[3], ON, 8'h80, ON, 16'h1432, OFF, OFF,
                                  32'h7FFF_FFFF));
      frame_queue.push_back(frame(ON, addr_pool[3], ON, 8'h80, ON, 16'h1432, OFF, OFF,
                                  32'h7FFF_FFFF));
      // beacon wins over probe on creation
      frame_queue.push_back(frame(ON, addr_pool[4], ON, 8'hAA, ON, 16'hAAAA, ON, ON,
                                  32'hAAAA_AAAA));
      frame_queue.push_back(frame(ON, addr_pool[5], ON, 8'h55, ON, 16'h5555, OFF, ON,
                                  32'h5555_5555));
      // an ignored frame must not touch a known station
      frame_queue.push_back(frame(OFF, addr_pool[0], ON, 8'h7F, ON, 16'h7777, ON, ON,
                                  32'h20));
      frame_queue.push_back(frame(ON, addr_pool[0], ON, 8'h00, ON, 16'h0000, OFF, OFF,
                                  32'h21));
      first_drain = frame_queue.size();

      while (frame_queue.size() < TOTAL_FRAMES)
         frame_queue.push_back(random_frame());
      total_frames = frame_queue.size();

      while (accepted_count < total_frames)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
